FILE: design/lcma_pkg.sv
// Package for the linked chain allocator: field widths, operation and status
// codes, result word type and default pool parameters. No dependencies.
`default_nettype none

package lcma_pkg;

    localparam int FUNC_W   = 3;
    localparam int ADDR_W   = 8;
    localparam int ID_TAG_W = 16;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    localparam int POOL_DEPTH_DEF = 256;
    localparam int TAG_BITS_DEF   = 16;

    localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUT     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_GET     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_COUNT   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_IS_FREE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUILDING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]          head_addr;
        logic signed [VALUE_W-1:0]  data_out;
        logic                       flag;
        logic [COUNT_W-1:0]         free_count;
        logic [COUNT_W-1:0]         used_count;
        logic [STATUS_W-1:0]        status;
    } res_t;

endpackage

`default_nettype wire

FILE: design/lcma_if.sv
// Valid/ready channel interfaces for the linked chain allocator: request word
// and response word. Depends on lcma_pkg.
`default_nettype none

interface lcma_req_if;
    import lcma_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [ADDR_W-1:0]         addr;
    logic [ID_TAG_W-1:0]       id_tag;
    logic signed [VALUE_W-1:0] value;
    logic                      last_id;

    modport source (output valid, func, addr, id_tag, value, last_id, input ready);
    modport sink   (input valid, func, addr, id_tag, value, last_id, output ready);
endinterface

interface lcma_rsp_if;
    import lcma_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ADDR_W-1:0]         head_addr;
    logic signed [VALUE_W-1:0] data_out;
    logic                      flag;
    logic [COUNT_W-1:0]        free_count;
    logic [COUNT_W-1:0]        used_count;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, head_addr, data_out, flag, free_count, used_count, status,
                    input ready);
    modport sink   (input valid, head_addr, data_out, flag, free_count, used_count, status,
                    output ready);
endinterface

`default_nettype wire

FILE: design/linked_chain_memory_allocator.sv
// Linked chain allocator top level: node pool memories, free list and walk sequencer.
// Depends on lcma_pkg and the lcma_req_if / lcma_rsp_if channel interfaces.
`default_nettype none

// Node pool of POOL_DEPTH entries (tag, value, link) in three single-port-write
// memories with registered reads; free nodes form one linked free list. After
// reset a clearing pass builds the initial free list and zeroes the values; no
// request word is taken meanwhile. One request word at a time: append passes
// through the prime and append states to the done state; a word that needs no
// walk (no space at chain start, unused code) goes straight to done; put, get,
// count and is-free prime the first read and then walk their list node by node,
// get and is-free stopping at a match; free walks the free list and then the
// chain, two node walks. The pace is one node per cycle, set by the link memory
// read port feeding the next read address. A finished result sits in an output
// register, so the next word can be taken while it waits.
module linked_chain_memory_allocator #(
    parameter int POOL_DEPTH = lcma_pkg::POOL_DEPTH_DEF,
    parameter int TAG_BITS   = lcma_pkg::TAG_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lcma_req_if.sink   req,
    lcma_rsp_if.source rsp
);
    import lcma_pkg::*;

    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int LINK_W = $clog2(POOL_DEPTH + 1);
    localparam int TW     = (TAG_BITS < ID_TAG_W) ? TAG_BITS : ID_TAG_W;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_DEPTH - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PRIME  = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // node pool
    logic [LINK_W-1:0]  link_mem  [POOL_DEPTH];
    logic [VALUE_W-1:0] value_mem [POOL_DEPTH];
    logic [TW-1:0]      tag_mem   [POOL_DEPTH];
    logic [LINK_W-1:0]  link_rd;
    logic [VALUE_W-1:0] value_rd;
    logic [TW-1:0]      tag_rd;

    logic [IDX_W-1:0]   rd_idx;
    logic               lw_en;
    logic [IDX_W-1:0]   lw_idx;
    logic [LINK_W-1:0]  lw_data;
    logic               vw_en;
    logic [IDX_W-1:0]   vw_idx;
    logic [VALUE_W-1:0] vw_data;
    logic               tw_en;

    // control state
    logic [2:0]        state_reg,       state_next;
    logic [IDX_W-1:0]  clr_reg,         clr_next;
    logic [LINK_W-1:0] cur_reg,         cur_next;
    logic [LINK_W-1:0] n_reg,           n_next;
    logic [FUNC_W-1:0] func_reg,        func_next;
    logic              free_ph2_reg,    free_ph2_next;
    logic [LINK_W-1:0] free_head_reg,   free_head_next;
    logic              building_reg,    building_next;
    logic [IDX_W-1:0]  chain_start_reg, chain_start_next;
    logic [IDX_W-1:0]  cursor_reg,      cursor_next;
    logic              out_valid_reg,   out_valid_next;

    // payload
    logic [ADDR_W-1:0]  addr_reg,  addr_next;
    logic [TW-1:0]      tag_reg,   tag_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg,  last_next;
    res_t               res_reg,   res_next;
    res_t               out_reg,   out_next;

    logic              n_ok;
    logic              active;
    logic              link_in;
    logic              tag_hit;
    logic              cur_is_addr;
    logic              req_addr_in;
    logic [IDX_W-1:0]  cur_idx;
    logic [LINK_W-1:0] used_full;

    assign cur_idx     = cur_reg[IDX_W-1:0];
    assign n_ok        = n_reg < NULL_LINK;
    assign active      = n_ok && (cur_reg < NULL_LINK);
    assign link_in     = link_rd < NULL_LINK;
    assign tag_hit     = tag_rd == tag_reg;
    assign cur_is_addr = cur_reg == LINK_W'(addr_reg);
    assign req_addr_in = 32'(req.addr) < 32'(POOL_DEPTH);
    assign used_full   = NULL_LINK - n_reg;
    assign rd_idx      = (state_reg == S_WALK) ? link_rd[IDX_W-1:0] : cur_idx;

    assign req.ready = state_reg == S_IDLE;

    assign rsp.valid      = out_valid_reg;
    assign rsp.head_addr  = out_reg.head_addr;
    assign rsp.data_out   = out_reg.data_out;
    assign rsp.flag       = out_reg.flag;
    assign rsp.free_count = out_reg.free_count;
    assign rsp.used_count = out_reg.used_count;
    assign rsp.status     = out_reg.status;

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_mem[lw_idx] <= lw_data;
        end
        if (vw_en)
        begin
            value_mem[vw_idx] <= vw_data;
        end
        if (tw_en)
        begin
            tag_mem[cur_idx] <= tag_reg;
        end
        link_rd  <= link_mem[rd_idx];
        value_rd <= value_mem[rd_idx];
        tag_rd   <= tag_mem[rd_idx];
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        cur_next         = cur_reg;
        n_next           = n_reg;
        func_next        = func_reg;
        free_ph2_next    = free_ph2_reg;
        free_head_next   = free_head_reg;
        building_next    = building_reg;
        chain_start_next = chain_start_reg;
        cursor_next      = cursor_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        addr_next        = addr_reg;
        tag_next         = tag_reg;
        value_next       = value_reg;
        last_next        = last_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        lw_en            = 1'b0;
        lw_idx           = cur_idx;
        lw_data          = NULL_LINK;
        vw_en            = 1'b0;
        vw_idx           = cur_idx;
        vw_data          = value_reg;
        tw_en            = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                lw_en    = 1'b1;
                lw_idx   = clr_reg;
                lw_data  = LINK_W'(clr_reg) + LINK_W'(1);
                vw_en    = 1'b1;
                vw_idx   = clr_reg;
                vw_data  = '0;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next     = req.func;
                    addr_next     = req.addr;
                    tag_next      = req.id_tag[TW-1:0];
                    value_next    = req.value;
                    last_next     = req.last_id;
                    res_next      = '0;
                    n_next        = '0;
                    free_ph2_next = 1'b0;
                    state_next    = S_PRIME;
                    if (req.func != FN_APPEND)
                    begin
                        building_next = 1'b0;
                    end
                    case (req.func)
                        FN_APPEND:
                        begin
                            if (building_reg)
                            begin
                                cur_next = LINK_W'(cursor_reg);
                            end
                            else if (free_head_reg >= NULL_LINK)
                            begin
                                res_next.status = ST_NO_SPACE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                chain_start_next = free_head_reg[IDX_W-1:0];
                                cursor_next      = free_head_reg[IDX_W-1:0];
                                building_next    = 1'b1;
                                cur_next         = free_head_reg;
                            end
                        end
                        FN_FREE, FN_IS_FREE:
                        begin
                            cur_next = free_head_reg;
                            if (!req_addr_in)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        FN_PUT, FN_GET:
                        begin
                            cur_next = req_addr_in ? LINK_W'(req.addr) : NULL_LINK;
                        end
                        FN_COUNT:
                        begin
                            cur_next = free_head_reg;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PRIME:
            begin
                state_next = (func_reg == FN_APPEND) ? S_APPEND : S_WALK;
            end
            S_APPEND:
            begin
                tw_en      = 1'b1;
                state_next = S_DONE;
                if (last_reg)
                begin
                    free_head_next     = link_rd;
                    lw_en              = 1'b1;
                    building_next      = 1'b0;
                    res_next.head_addr = ADDR_W'(chain_start_reg);
                    res_next.status    = ST_DONE;
                end
                else if (!link_in)
                begin
                    building_next   = 1'b0;
                    res_next.status = ST_NO_SPACE;
                end
                else
                begin
                    cursor_next     = link_rd[IDX_W-1:0];
                    res_next.status = ST_BUILDING;
                end
            end
            S_WALK:
            begin
                cur_next = link_rd;
                n_next   = n_reg + LINK_W'(1);
                case (func_reg)
                    FN_FREE:
                    begin
                        if (!free_ph2_reg)
                        begin
                            if (!active)
                            begin
                                free_ph2_next = 1'b1;
                                cur_next      = LINK_W'(addr_reg);
                                n_next        = '0;
                                state_next    = S_PRIME;
                            end
                            else if (cur_is_addr)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        else if (!n_ok)
                        begin
                            state_next = S_DONE;
                        end
                        else if (!link_in)
                        begin
                            lw_en          = 1'b1;
                            lw_data        = free_head_reg;
                            free_head_next = LINK_W'(addr_reg);
                            state_next     = S_DONE;
                        end
                    end
                    FN_PUT:
                    begin
                        if (active)
                        begin
                            vw_en = tag_hit;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    FN_GET:
                    begin
                        if (active && tag_hit)
                        begin
                            res_next.data_out = value_rd;
                            res_next.flag     = 1'b1;
                            state_next        = S_DONE;
                        end
                        else if (!active)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    FN_COUNT:
                    begin
                        if (!active)
                        begin
                            res_next.free_count = COUNT_W'(n_reg);
                            res_next.used_count = COUNT_W'(used_full);
                            state_next          = S_DONE;
                        end
                    end
                    FN_IS_FREE:
                    begin
                        if (active && cur_is_addr)
                        begin
                            res_next.flag = 1'b1;
                            state_next    = S_DONE;
                        end
                        else if (!active)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            cur_reg         <= '0;
            n_reg           <= '0;
            func_reg        <= FN_APPEND;
            free_ph2_reg    <= 1'b0;
            free_head_reg   <= '0;
            building_reg    <= 1'b0;
            chain_start_reg <= '0;
            cursor_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            cur_reg         <= cur_next;
            n_reg           <= n_next;
            func_reg        <= func_next;
            free_ph2_reg    <= free_ph2_next;
            free_head_reg   <= free_head_next;
            building_reg    <= building_next;
            chain_start_reg <= chain_start_next;
            cursor_reg      <= cursor_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        tag_reg   <= tag_next;
        value_reg <= value_next;
        last_reg  <= last_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

FILE: tb/lcma_chain_checker.sv
// Scoreboard for the linked chain allocator: keeps its own node pool, predicts
// each response word and compares it with the block. Depends on lcma_pkg, lcma_if.
module lcma_chain_checker (
    input  logic  clk,
    input  logic  rst_n,
    lcma_req_if   req,
    lcma_rsp_if   rsp,
    output int    fail_count,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lcma_pkg::*;

    localparam int         POOL      = POOL_DEPTH_DEF;
    localparam logic [8:0] NULL_LINK = 9'(POOL);
    localparam int         MAX_MSGS  = 200;

    logic [ID_TAG_W-1:0]       tag_mem   [POOL];
    logic signed [VALUE_W-1:0] value_mem [POOL];
    logic [8:0]                link_mem  [POOL];
    logic [8:0]                free_head;
    logic                      building;
    logic [ADDR_W-1:0]         chain_start;
    logic [ADDR_W-1:0]         cursor;

    res_t want_q [$];
    res_t want;

    function automatic void pool_reset();
        int i;
        for (i = 0; i < POOL; i++)
        begin
            tag_mem[i]   = '0;
            value_mem[i] = '0;
            link_mem[i]  = 9'(i + 1);
        end
        link_mem[POOL-1] = NULL_LINK;
        free_head   = '0;
        building    = 1'b0;
        chain_start = '0;
        cursor      = '0;
    endfunction

    function automatic bit on_free_list(logic [8:0] a);
        logic [8:0] x;
        int n;
        x = free_head;
        for (n = 0; n < POOL && x < POOL; n++)
        begin
            if (x == a)
                return 1'b1;
            x = link_mem[x[7:0]];
        end
        return 1'b0;
    endfunction

    function automatic int free_nodes();
        logic [8:0] x;
        int n;
        x = free_head;
        n = 0;
        while (n < POOL && x < POOL)
        begin
            n++;
            x = link_mem[x[7:0]];
        end
        return n;
    endfunction

    // chain goes back on the free list; double frees and endless chains are dropped
    function automatic void return_chain(logic [ADDR_W-1:0] a);
        logic [8:0] x;
        logic [8:0] nxt;
        int n;
        if (on_free_list({1'b0, a}))
            return;
        x = {1'b0, a};
        for (n = 0; n < POOL; n++)
        begin
            nxt = link_mem[x[7:0]];
            if (nxt >= POOL)
            begin
                link_mem[x[7:0]] = free_head;
                free_head = {1'b0, a};
                return;
            end
            x = nxt;
        end
    endfunction

    function automatic res_t pool_step(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] a,
                                       logic [ID_TAG_W-1:0] tag,
                                       logic signed [VALUE_W-1:0] val, logic last);
        res_t r;
        logic [8:0] x;
        int n;
        int cnt;
        r = '0;
        if (fn != FN_APPEND)
            building = 1'b0;
        case (fn)
            FN_APPEND:
            begin
                if (!building && free_head >= POOL)
                    r.status = ST_NO_SPACE;
                else
                begin
                    if (!building)
                    begin
                        chain_start = free_head[7:0];
                        cursor      = free_head[7:0];
                        building    = 1'b1;
                    end
                    tag_mem[cursor] = tag;
                    if (last)
                    begin
                        free_head        = link_mem[cursor];
                        link_mem[cursor] = NULL_LINK;
                        building         = 1'b0;
                        r.head_addr      = chain_start;
                        r.status         = ST_DONE;
                    end
                    else if (link_mem[cursor] >= POOL)
                    begin
                        building = 1'b0;
                        r.status = ST_NO_SPACE;
                    end
                    else
                    begin
                        cursor   = link_mem[cursor][7:0];
                        r.status = ST_BUILDING;
                    end
                end
            end
            FN_FREE:
                return_chain(a);
            FN_PUT:
            begin
                x = {1'b0, a};
                for (n = 0; n < POOL && x < POOL; n++)
                begin
                    if (tag_mem[x[7:0]] == tag)
                        value_mem[x[7:0]] = val;
                    x = link_mem[x[7:0]];
                end
            end
            FN_GET:
            begin
                x = {1'b0, a};
                for (n = 0; n < POOL && x < POOL; n++)
                begin
                    if (tag_mem[x[7:0]] == tag)
                    begin
                        r.data_out = value_mem[x[7:0]];
                        r.flag     = 1'b1;
                        break;
                    end
                    x = link_mem[x[7:0]];
                end
            end
            FN_COUNT:
            begin
                cnt          = free_nodes();
                r.free_count = COUNT_W'(cnt);
                r.used_count = COUNT_W'(POOL - cnt);
            end
            FN_IS_FREE:
                r.flag = on_free_list({1'b0, a});
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp)
        begin
            if (fail_count < MAX_MSGS)
                $error("%s: expected %0h, got %0h", name, exp, act);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reset();
            want_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (want_q.size() == 0)
                begin
                    if (fail_count < MAX_MSGS)
                        $error("response word with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = want_q.pop_front();
                    check_field("head_addr", 32'(want.head_addr), 32'(rsp.head_addr));
                    check_field("data_out", want.data_out, rsp.data_out);
                    check_field("flag", 32'(want.flag), 32'(rsp.flag));
                    check_field("free_count", 32'(want.free_count), 32'(rsp.free_count));
                    check_field("used_count", 32'(want.used_count), 32'(rsp.used_count));
                    check_field("status", 32'(want.status), 32'(rsp.status));
                end
            end
            if (req.valid && req.ready)
                want_q.push_back(pool_step(req.func, req.addr, req.id_tag, req.value,
                                           req.last_id));
            pending <= want_q.size();
        end
    end

endmodule

FILE: tb/linked_chain_memory_allocator_tb.sv
// Top of the allocator testbench: clock, reset, request and response traffic
// with random stalls. Depends on lcma_pkg, lcma_if and lcma_chain_checker.
module linked_chain_memory_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lcma_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_LO    = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI    = 3'd7;
    localparam int                RANDOM_WORDS   = 1370;
    localparam int                QUIET_TAIL     = 200;
    localparam int                DRAIN_EVERY    = 500;
    localparam int                WATCHDOG_LIMIT = 5000;

    logic clk;
    logic rst_n;
    bit   gaps_on;
    int   stall_left;
    int   quiet_cycles;
    int   words_sent;
    int   fail_count;
    int   pending;

    logic [FUNC_W-1:0] op_log [$];
    logic [ADDR_W-1:0] live_heads [$];
    logic [FUNC_W-1:0] done_fn;

    lcma_req_if req_ch ();
    lcma_rsp_if rsp_ch ();

    linked_chain_memory_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lcma_chain_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= (stall_left == 1);
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(1, 10);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // completed chains become candidates for free, put, get and is-free
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready && op_log.size() != 0)
        begin
            done_fn = op_log.pop_front();
            if (done_fn == FN_APPEND && rsp_ch.status == ST_DONE)
                live_heads.push_back(rsp_ch.head_addr);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rnd_addr();
        return ADDR_W'($urandom);
    endfunction

    function automatic logic [ID_TAG_W-1:0] rnd_tag();
        return ID_TAG_W'($urandom);
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom);
    endfunction

    function automatic logic [ID_TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'h8000;
            4: return 16'h5555;
            5: return 16'hAAAA;
            default: return rnd_tag();
        endcase
    endfunction

    task automatic send_word(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] a,
                             logic [ID_TAG_W-1:0] tag, logic [VALUE_W-1:0] val,
                             logic last);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.func    <= fn;
        req_ch.addr    <= a;
        req_ch.id_tag  <= tag;
        req_ch.value   <= val;
        req_ch.last_id <= last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        op_log.push_back(fn);
        words_sent++;
    endtask

    task automatic wait_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int i;
        int k;
        int len;
        int pick;
        int rand_end;
        int quiet_from;
        int next_drain;
        bit cut;
        logic [ADDR_W-1:0] a;

        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.func    <= FN_APPEND;
        req_ch.addr    <= '0;
        req_ch.id_tag  <= '0;
        req_ch.value   <= '0;
        req_ch.last_id <= 1'b0;
        gaps_on         = 1'b1;
        words_sent      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole pool: chain of 253 at node 0, chain of 3 at node 253
        for (i = 0; i < POOL_DEPTH_DEF; i++)
            send_word(FN_APPEND, rnd_addr(),
                      (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : pick_tag(),
                      $urandom, (i == 252 || i == POOL_DEPTH_DEF - 1));
        wait_results();

        send_word(FN_APPEND, rnd_addr(), pick_tag(), $urandom, 1'b1);   // empty free list
        send_word(FN_COUNT, rnd_addr(), rnd_tag(), $urandom, rnd_bit());
        send_word(FN_IS_FREE, 8'd10, rnd_tag(), $urandom, rnd_bit());
        send_word(FN_PUT, 8'd0, 16'hFFFF, 32'h7FFF_FFFF, rnd_bit());
        send_word(FN_PUT, 8'd0, 16'h0000, 32'h8000_0000, rnd_bit());
        send_word(FN_GET, 8'd0, 16'hFFFF, $urandom, rnd_bit());
        send_word(FN_GET, 8'd0, 16'h0000, $urandom, rnd_bit());
        send_word(FN_GET, 8'd0, 16'h1357, $urandom, rnd_bit());
        send_word(FN_GET, 8'd255, 16'hAAAA, $urandom, rnd_bit());
        send_word(FN_FREE, 8'd253, rnd_tag(), $urandom, rnd_bit());
        send_word(FN_FREE, 8'd253, rnd_tag(), $urandom, rnd_bit());     // double free
        send_word(FN_FREE, 8'd254, rnd_tag(), $urandom, rnd_bit());     // node already free
        send_word(FN_IS_FREE, 8'd255, rnd_tag(), $urandom, rnd_bit());
        for (i = 0; i < 3; i++)                                         // runs out mid-chain
            send_word(FN_APPEND, rnd_addr(), pick_tag(), $urandom, 1'b0);
        send_word(FN_APPEND, rnd_addr(), pick_tag(), $urandom, 1'b1);
        send_word(FN_APPEND, rnd_addr(), pick_tag(), $urandom, 1'b0);
        send_word(FN_COUNT, rnd_addr(), rnd_tag(), $urandom, rnd_bit());  // aborts the chain
        send_word(FN_SPARE_LO, rnd_addr(), rnd_tag(), $urandom, rnd_bit());
        send_word(FN_SPARE_HI, rnd_addr(), rnd_tag(), $urandom, rnd_bit());
        send_word(FN_FREE, 8'd0, rnd_tag(), $urandom, rnd_bit());
        send_word(FN_FREE, 8'd253, rnd_tag(), $urandom, rnd_bit());
        send_word(FN_COUNT, rnd_addr(), rnd_tag(), $urandom, rnd_bit());
        send_word(FN_IS_FREE, 8'd0, rnd_tag(), $urandom, rnd_bit());
        wait_results();
        live_heads.delete();

        rand_end   = words_sent + RANDOM_WORDS;
        quiet_from = rand_end - QUIET_TAIL;
        next_drain = words_sent + DRAIN_EVERY;
        while (words_sent < rand_end)
        begin
            if (words_sent >= quiet_from)
                gaps_on = 1'b0;
            if (words_sent >= next_drain)
            begin
                wait_results();
                next_drain += DRAIN_EVERY;
            end
            pick = $urandom_range(0, 99);
            if (live_heads.size() > 6 && pick < 50)
                pick = 50;
            if (pick < 45)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
                cut = ($urandom_range(0, 9) == 0);
                for (k = 0; k < len; k++)
                    send_word(FN_APPEND, rnd_addr(), pick_tag(), $urandom,
                              (k == len - 1) && !cut);
            end
            else if (pick < 57)
            begin
                if (live_heads.size() != 0 && $urandom_range(0, 19) != 0)
                begin
                    k = $urandom_range(0, live_heads.size() - 1);
                    a = live_heads[k];
                    live_heads.delete(k);
                end
                else
                    a = rnd_addr();
                send_word(FN_FREE, a, pick_tag(), $urandom, rnd_bit());
            end
            else if (pick < 96 && !(pick >= 84 && pick < 90))
            begin
                if (live_heads.size() != 0 && $urandom_range(0, 9) < 7)
                    a = live_heads[$urandom_range(0, live_heads.size() - 1)];
                else
                    a = rnd_addr();
                send_word((pick < 69) ? FN_PUT : (pick < 84) ? FN_GET : FN_IS_FREE,
                          a, pick_tag(), $urandom, rnd_bit());
            end
            else if (pick < 90)
                send_word(FN_COUNT, rnd_addr(), rnd_tag(), $urandom, rnd_bit());
            else
                send_word($urandom_range(0, 1) ? FN_SPARE_LO : FN_SPARE_HI,
                          rnd_addr(), rnd_tag(), $urandom, rnd_bit());
        end

        wait_results();
        repeat (600) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
design/lcma_pkg.sv
design/lcma_if.sv
design/linked_chain_memory_allocator.sv
tb/lcma_chain_checker.sv
tb/linked_chain_memory_allocator_tb.sv
